/* rtl/swtc_pkg.sv */
// ----------------------------------------------------------------------------
// swtc_pkg
// Types, constants and lookup tables for the square wave tone channel.
// ----------------------------------------------------------------------------
package swtc_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TIMER  = 2'd1,
    REQ_SWEEP  = 2'd2,
    REQ_LENGTH = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    REG_ENV    = 2'd0,
    REG_SWEEP  = 2'd1,
    REG_PLO    = 2'd2,
    REG_PHI    = 2'd3
  } reg_sel_t;

  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_FIRST  = 1'b1
  } cfg_sel_t;

  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned TARGET_W = PERIOD_W + 1;
  localparam logic [7:0] STEP_FIRST = 8'h80;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd8;

  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'h40;
      2'd1:    pat = 8'h60;
      2'd2:    pat = 8'h78;
      default: pat = 8'h9F;
    endcase
    return pat;
  endfunction

  function automatic logic [7:0] length_load(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:    val = 8'd10;
      5'd1:    val = 8'd254;
      5'd2:    val = 8'd20;
      5'd3:    val = 8'd2;
      5'd4:    val = 8'd40;
      5'd5:    val = 8'd4;
      5'd6:    val = 8'd80;
      5'd7:    val = 8'd6;
      5'd8:    val = 8'd160;
      5'd9:    val = 8'd8;
      5'd10:   val = 8'd60;
      5'd11:   val = 8'd10;
      5'd12:   val = 8'd14;
      5'd13:   val = 8'd12;
      5'd14:   val = 8'd26;
      5'd15:   val = 8'd14;
      5'd16:   val = 8'd12;
      5'd17:   val = 8'd16;
      5'd18:   val = 8'd24;
      5'd19:   val = 8'd18;
      5'd20:   val = 8'd48;
      5'd21:   val = 8'd20;
      5'd22:   val = 8'd96;
      5'd23:   val = 8'd22;
      5'd24:   val = 8'd192;
      5'd25:   val = 8'd24;
      5'd26:   val = 8'd72;
      5'd27:   val = 8'd26;
      5'd28:   val = 8'd16;
      5'd29:   val = 8'd28;
      5'd30:   val = 8'd32;
      default: val = 8'd30;
    endcase
    return val;
  endfunction

endpackage

/* rtl/square_wave_tone_channel.sv */
// ----------------------------------------------------------------------------
// square_wave_tone_channel
// Pulse tone channel: register writes, timer ticks, sweep and length clocks.
// ----------------------------------------------------------------------------
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid / in_stall   | req_type, reg_index, write_data
//   out     | source    | out_valid / out_stall | duty_bit .. envelope_restart
//   cfg     | sink      | cfg_write             | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; its result is registered and appears in the cycle after acceptance.
// The channel state and the result register update at the same edge.
// in_stall is high during rst and while a result is held and out_stall is high.
// rst is synchronous and clears the channel state and out_valid, not the result data; no clearing pass is needed.
module square_wave_tone_channel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [1:0]                    reg_index,
  input  logic [7:0]                    write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          duty_bit,
  output logic                          sweep_muting,
  output logic [7:0]                    length_count,
  output logic [swtc_pkg::PERIOD_W-1:0] timer_period,
  output logic [3:0]                    volume_setting,
  output logic                          constant_volume,
  output logic                          envelope_restart
);
  import swtc_pkg::*;

  logic                channel_enabled;
  logic                first_channel;

  logic [1:0]          duty_select, duty_select_next;
  logic                halt_loop, halt_loop_next;
  logic                const_vol, const_vol_next;
  logic [3:0]          vol_value, vol_value_next;
  logic                start_mark, start_mark_next;
  logic                sweep_on, sweep_on_next;
  logic [3:0]          sweep_reload_value, sweep_reload_value_next;
  logic                sweep_negate, sweep_negate_next;
  logic [2:0]          sweep_shift, sweep_shift_next;
  logic                sweep_reload_pending, sweep_reload_pending_next;
  logic [7:0]          sweep_divider, sweep_divider_next;
  logic [TARGET_W-1:0] target_period, target_period_next;
  logic [PERIOD_W-1:0] period_reload, period_reload_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic [7:0]          step_position, step_position_next;
  logic                wave_bit, wave_bit_next;
  logic [7:0]          length_remaining, length_remaining_next;

  logic                in_accept;
  logic [PERIOD_W-1:0] change;
  logic [TARGET_W-1:0] target_calc;
  logic [7:0]          div_dec;
  logic                retune;
  logic                mute_next;

  assign in_stall  = rst | (out_valid & out_stall);
  assign in_accept = in_valid & ~in_stall;

  // sweep target from the updated period and sweep settings
  assign change = period_reload_next >> sweep_shift_next;
  always_comb begin
    if (sweep_negate_next) begin
      target_calc = {1'b0, period_reload_next} - {1'b0, change}
                    - {{(TARGET_W-1){1'b0}}, first_channel};
    end else begin
      target_calc = {1'b0, period_reload_next} + {1'b0, change};
    end
  end

  assign div_dec = sweep_divider - 8'd1;
  assign retune  = (sweep_shift != 3'd0) && sweep_on && (period_reload >= PERIOD_MIN)
                   && !target_period[TARGET_W-1];

  always_comb begin
    duty_select_next          = duty_select;
    halt_loop_next            = halt_loop;
    const_vol_next            = const_vol;
    vol_value_next            = vol_value;
    start_mark_next           = start_mark;
    sweep_on_next             = sweep_on;
    sweep_reload_value_next   = sweep_reload_value;
    sweep_negate_next         = sweep_negate;
    sweep_shift_next          = sweep_shift;
    sweep_reload_pending_next = sweep_reload_pending;
    sweep_divider_next        = sweep_divider;
    period_reload_next        = period_reload;
    period_count_next         = period_count;
    step_position_next        = step_position;
    length_remaining_next     = length_remaining;
    unique case (req_kind_t'(req_type))
      REQ_WRITE: begin
        step_position_next = STEP_FIRST;
        unique case (reg_sel_t'(reg_index))
          REG_ENV: begin
            duty_select_next = write_data[7:6];
            halt_loop_next   = write_data[5];
            const_vol_next   = write_data[4];
            vol_value_next   = write_data[3:0];
            start_mark_next  = 1'b1;
          end
          REG_SWEEP: begin
            sweep_on_next             = write_data[7];
            sweep_reload_value_next   = {1'b0, write_data[6:4]} + 4'd1;
            sweep_negate_next         = write_data[3];
            sweep_shift_next          = write_data[2:0];
            sweep_reload_pending_next = 1'b1;
          end
          REG_PLO: begin
            period_reload_next = {period_reload[PERIOD_W-1:8], write_data};
          end
          REG_PHI: begin
            if (channel_enabled) begin
              length_remaining_next = length_load(write_data[7:3]);
            end
            period_reload_next = {write_data[2:0], period_reload[7:0]};
            start_mark_next    = 1'b1;
          end
          default: ;
        endcase
      end
      REQ_TIMER: begin
        if (period_count != '0) begin
          period_count_next = period_count - 1'b1;
        end else begin
          period_count_next  = period_reload;
          step_position_next = {step_position[0], step_position[7:1]};
        end
      end
      REQ_SWEEP: begin
        sweep_divider_next = div_dec;
        if (div_dec == 8'd0) begin
          if (retune) begin
            period_reload_next = target_period[PERIOD_W-1:0];
          end
          sweep_divider_next = {4'd0, sweep_reload_value};
        end
        if (sweep_reload_pending) begin
          sweep_divider_next        = {4'd0, sweep_reload_value};
          sweep_reload_pending_next = 1'b0;
        end
      end
      REQ_LENGTH: begin
        if ((length_remaining != 8'd0) && !halt_loop) begin
          length_remaining_next = length_remaining - 8'd1;
        end
      end
      default: ;
    endcase
  end

  // wave refresh on envelope and high-period writes and on a duty step
  always_comb begin
    wave_bit_next = wave_bit;
    if ((req_type == REQ_WRITE && (reg_index == REG_ENV || reg_index == REG_PHI))
        || (req_type == REQ_TIMER && period_count == '0)) begin
      wave_bit_next = |(duty_pattern(duty_select_next) & step_position_next);
    end
  end

  always_comb begin
    target_period_next = target_period;
    if ((req_type == REQ_TIMER) || (req_type == REQ_WRITE && reg_index == REG_SWEEP)) begin
      target_period_next = target_calc;
    end
  end

  assign mute_next = (period_reload_next < PERIOD_MIN)
                     || (!sweep_negate_next && target_period_next[TARGET_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enabled <= 1'b0;
      first_channel   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_sel_t'(cfg_index))
        CFG_ENABLE: channel_enabled <= cfg_data;
        CFG_FIRST:  first_channel   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_select          <= '0;
      halt_loop            <= 1'b0;
      const_vol            <= 1'b0;
      vol_value            <= '0;
      start_mark           <= 1'b0;
      sweep_on             <= 1'b0;
      sweep_reload_value   <= '0;
      sweep_negate         <= 1'b0;
      sweep_shift          <= '0;
      sweep_reload_pending <= 1'b0;
      sweep_divider        <= '0;
      target_period        <= '0;
      period_reload        <= '0;
      period_count         <= '0;
      step_position        <= STEP_FIRST;
      wave_bit             <= 1'b0;
      length_remaining     <= '0;
    end else if (in_accept) begin
      duty_select          <= duty_select_next;
      halt_loop            <= halt_loop_next;
      const_vol            <= const_vol_next;
      vol_value            <= vol_value_next;
      start_mark           <= start_mark_next;
      sweep_on             <= sweep_on_next;
      sweep_reload_value   <= sweep_reload_value_next;
      sweep_negate         <= sweep_negate_next;
      sweep_shift          <= sweep_shift_next;
      sweep_reload_pending <= sweep_reload_pending_next;
      sweep_divider        <= sweep_divider_next;
      target_period        <= target_period_next;
      period_reload        <= period_reload_next;
      period_count         <= period_count_next;
      step_position        <= step_position_next;
      wave_bit             <= wave_bit_next;
      length_remaining     <= length_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      duty_bit         <= wave_bit_next;
      sweep_muting     <= mute_next;
      length_count     <= length_remaining_next;
      timer_period     <= period_reload_next;
      volume_setting   <= vol_value_next;
      constant_volume  <= const_vol_next;
      envelope_restart <= start_mark_next;
    end
  end

endmodule

/* rtl/swtc_checker.sv */
// ----------------------------------------------------------------------------
// swtc_checker
// Port-level checks for the square wave tone channel, bound to the top level.
// ----------------------------------------------------------------------------
module swtc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    req_type,
  input logic [1:0]                    reg_index,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          sweep_muting,
  input logic [swtc_pkg::PERIOD_W-1:0] timer_period,
  input logic                          envelope_restart
);
  import swtc_pkg::*;

  // stall only while a held result is not taken
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  a_env_restart: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_WRITE
     && (reg_index == REG_ENV || reg_index == REG_PHI)) |=> envelope_restart)
    else $error("envelope restart not set after write");

  a_short_mutes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && timer_period < PERIOD_MIN) |-> sweep_muting)
    else $error("short period not muted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(timer_period)))
    else $error("stalled result changed");

endmodule

bind square_wave_tone_channel swtc_checker u_swtc_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .req_type         (req_type),
  .reg_index        (reg_index),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .sweep_muting     (sweep_muting),
  .timer_period     (timer_period),
  .envelope_restart (envelope_restart)
);
